// ===== sv/tmcw_pkg.sv =====
// Shared types and constants of the text-mode console writer.
`default_nettype none
package tmcw_pkg;

	localparam int LINE_W  = 5;
	localparam int COL_W   = 7;
	localparam int IDX_W   = 11;
	localparam int CELL_W  = 16;
	localparam int COLOR_W = 4;
	localparam int KIND_W  = 3;
	localparam int BYTE_W  = 8;
	// Wide enough for row * cols + col at the largest screen.
	localparam int LIN_W   = LINE_W + COL_W;

	localparam logic [KIND_W-1:0] KIND_GLYPH  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MOVE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SCROLL = 3'd4;

	localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'd32;

	localparam logic CFG_FG_COLOR = 1'b0;
	localparam logic CFG_BG_COLOR = 1'b1;

	localparam logic [COLOR_W-1:0] FG_RESET = 4'd0;
	localparam logic [COLOR_W-1:0] BG_RESET = 4'd15;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_SWEEP,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load_item;
		logic exec;
		logic load_cell;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic is_read;
		logic sweep_req;
		logic sweep_done;
	} status_t;

endpackage
`default_nettype wire

// ===== sv/tmcw_ctrl.sv =====
// Controller state machine of the text-mode console writer.
`default_nettype none
module tmcw_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	input  wire tmcw_pkg::status_t status,
	output tmcw_pkg::cmd_t        cmd
);

	tmcw_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic push_ok;

	assign push_ok  = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tmcw_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_tready      = 1'b0;
		unique case (state_q)
			tmcw_pkg::ST_IDLE: begin
				s_tready      = 1'b1;
				cmd.load_item = s_tvalid;
				if (s_tvalid) begin
					state_d = tmcw_pkg::ST_EXEC;
				end
			end
			tmcw_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				if (status.is_read) begin
					state_d = tmcw_pkg::ST_RDWAIT;
				end else if (status.sweep_req) begin
					state_d = tmcw_pkg::ST_SWEEP;
				end else begin
					state_d = tmcw_pkg::ST_RESP;
				end
			end
			tmcw_pkg::ST_RDWAIT: begin
				cmd.load_cell = 1'b1;
				state_d       = tmcw_pkg::ST_RESP;
			end
			tmcw_pkg::ST_SWEEP: begin
				if (status.sweep_done) begin
					state_d = tmcw_pkg::ST_RESP;
				end
			end
			tmcw_pkg::ST_RESP: begin
				// The next item may enter in the cycle the result is posted.
				if (push_ok) begin
					cmd.push      = 1'b1;
					s_tready      = 1'b1;
					cmd.load_item = s_tvalid;
					state_d       = s_tvalid ? tmcw_pkg::ST_EXEC : tmcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tmcw_pkg::ST_IDLE;
			end
		endcase
	end

	a_push_in_resp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> state_q == tmcw_pkg::ST_RESP)
		else $error("result posted outside the response state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !cmd.push)
		else $error("pending result overwritten");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_item |=> state_q == tmcw_pkg::ST_EXEC)
		else $error("accepted transaction not executed");

endmodule
`default_nettype wire

// ===== sv/tmcw_dpath.sv =====
// Datapath of the text-mode console writer: cursor, screen store and sweep engine.
`default_nettype none
module tmcw_dpath #(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tmcw_pkg::cmd_t                cmd,
	output tmcw_pkg::status_t                  status,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_sel,
	input  wire logic [tmcw_pkg::COLOR_W-1:0]  cfg_value,
	input  wire logic [tmcw_pkg::KIND_W-1:0]   in_kind,
	input  wire logic [tmcw_pkg::BYTE_W-1:0]   in_glyph,
	input  wire logic [tmcw_pkg::BYTE_W-1:0]   in_row,
	input  wire logic [tmcw_pkg::BYTE_W-1:0]   in_col,
	input  wire logic [tmcw_pkg::BYTE_W-1:0]   in_count,
	output logic [tmcw_pkg::IDX_W-1:0]         out_index,
	output logic [tmcw_pkg::LINE_W-1:0]        out_line,
	output logic [tmcw_pkg::COL_W-1:0]         out_column,
	output logic [tmcw_pkg::CELL_W-1:0]        out_cell
);

	localparam int CELLS  = SCREEN_ROWS * SCREEN_COLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int SRC_W  = ADDR_W + 1;
	localparam int CNT_W  = 6;

	localparam logic [tmcw_pkg::LINE_W-1:0] LAST_LINE = tmcw_pkg::LINE_W'(SCREEN_ROWS - 1);
	localparam logic [tmcw_pkg::COL_W-1:0]  LAST_COL  = tmcw_pkg::COL_W'(SCREEN_COLS - 1);

	// Item registers.
	logic [tmcw_pkg::KIND_W-1:0] kind_q;
	logic [tmcw_pkg::BYTE_W-1:0] glyph_q, row_q, col_in_q, count_q;

	// Cursor and colors.
	logic [tmcw_pkg::LINE_W-1:0]  line_q;
	logic [tmcw_pkg::COL_W-1:0]   col_q;
	logic [tmcw_pkg::COLOR_W-1:0] fg_q, bg_q;
	logic [tmcw_pkg::CELL_W-1:0]  cell_q;
	logic                         read_ok_q;

	// Sweep engine.
	logic              active_q;
	logic [ADDR_W-1:0] dst_q;
	logic [SRC_W-1:0]  src_q;
	logic              valid_s1;
	logic              copy_s1;
	logic [ADDR_W-1:0] dst_s1;

	// Screen store.
	logic [tmcw_pkg::CELL_W-1:0] mem [CELLS];
	logic [tmcw_pkg::CELL_W-1:0] rdata_q;
	logic                        we;
	logic [ADDR_W-1:0]           waddr, raddr;
	logic [tmcw_pkg::CELL_W-1:0] wdata;

	logic [tmcw_pkg::CELL_W-1:0] blank;
	logic [tmcw_pkg::CELL_W-1:0] glyph_entry;
	logic                        is_nl, row_ok, col_ok, at_line_end, overflow;
	logic                        sweep_req;
	logic [tmcw_pkg::LIN_W-1:0]  cur_lin, tgt_lin;
	logic [CNT_W-1:0]            cnt;
	logic [SRC_W-1:0]            offset;
	logic [tmcw_pkg::LINE_W-1:0] line_nx;
	logic [tmcw_pkg::COL_W-1:0]  col_nx;

	assign blank       = {bg_q, fg_q, tmcw_pkg::SPACE_CODE};
	assign glyph_entry = {bg_q, fg_q, glyph_q};
	assign is_nl       = glyph_q == tmcw_pkg::NEWLINE_CODE;
	assign row_ok      = row_q < 8'(SCREEN_ROWS);
	assign col_ok      = col_in_q < 8'(SCREEN_COLS);
	assign at_line_end = is_nl || col_q == LAST_COL;
	assign overflow    = at_line_end && line_q == LAST_LINE;

	assign cur_lin = tmcw_pkg::LIN_W'(line_q) * tmcw_pkg::LIN_W'(SCREEN_COLS)
		+ tmcw_pkg::LIN_W'(col_q);
	assign tgt_lin = tmcw_pkg::LIN_W'(row_q[tmcw_pkg::LINE_W-1:0])
		* tmcw_pkg::LIN_W'(SCREEN_COLS) + tmcw_pkg::LIN_W'(col_in_q[tmcw_pkg::COL_W-1:0]);

	// Rows to shift: a clear shifts the whole screen out, a scroll its count up to the whole screen, a wrap one row.
	always_comb begin
		priority if (kind_q == tmcw_pkg::KIND_CLEAR) begin
			cnt = CNT_W'(SCREEN_ROWS);
		end else if (kind_q == tmcw_pkg::KIND_SCROLL) begin
			cnt = (count_q > 8'(SCREEN_ROWS)) ? CNT_W'(SCREEN_ROWS) : count_q[CNT_W-1:0];
		end else begin
			cnt = CNT_W'(1);
		end
	end
	assign offset = SRC_W'(13'(cnt) * 13'(SCREEN_COLS));

	always_comb begin
		unique case (kind_q)
			tmcw_pkg::KIND_GLYPH:  sweep_req = overflow;
			tmcw_pkg::KIND_CLEAR:  sweep_req = 1'b1;
			tmcw_pkg::KIND_SCROLL: sweep_req = count_q != '0;
			default:               sweep_req = 1'b0;
		endcase
	end
	assign status.sweep_req  = sweep_req;
	assign status.is_read    = kind_q == tmcw_pkg::KIND_READ;
	assign status.sweep_done = !active_q && !valid_s1;

	// Cursor after a glyph or newline.
	always_comb begin
		line_nx = line_q;
		col_nx  = col_q + 1'b1;
		if (at_line_end) begin
			col_nx = '0;
			if (line_q != LAST_LINE) begin
				line_nx = line_q + 1'b1;
			end
		end
	end

	// Store ports: the glyph write and the sweep write never overlap.
	always_comb begin
		we    = 1'b0;
		waddr = dst_s1;
		wdata = copy_s1 ? rdata_q : blank;
		raddr = src_q[ADDR_W-1:0];
		if (valid_s1) begin
			we = 1'b1;
		end else if (cmd.exec && kind_q == tmcw_pkg::KIND_GLYPH && !is_nl) begin
			we    = 1'b1;
			waddr = cur_lin[ADDR_W-1:0];
			wdata = glyph_entry;
		end
		if (!active_q) begin
			raddr = tgt_lin[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q   <= in_kind;
			glyph_q  <= in_glyph;
			row_q    <= in_row;
			col_in_q <= in_col;
			count_q  <= in_count;
		end
		if (cmd.exec) begin
			read_ok_q <= row_ok && col_ok;
			cell_q    <= '0;
		end else if (cmd.load_cell) begin
			cell_q <= read_ok_q ? rdata_q : '0;
		end
		if (cmd.exec && sweep_req) begin
			dst_q <= '0;
			src_q <= offset;
		end else if (active_q) begin
			dst_q <= dst_q + 1'b1;
			src_q <= src_q + 1'b1;
		end
		dst_s1  <= dst_q;
		copy_s1 <= src_q < SRC_W'(CELLS);
		if (cmd.push) begin
			out_index  <= cur_lin[tmcw_pkg::IDX_W-1:0];
			out_line   <= line_q;
			out_column <= col_q;
			out_cell   <= cell_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= '0;
			col_q    <= '0;
			fg_q     <= tmcw_pkg::FG_RESET;
			bg_q     <= tmcw_pkg::BG_RESET;
			active_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_sel)
					tmcw_pkg::CFG_FG_COLOR: fg_q <= cfg_value;
					tmcw_pkg::CFG_BG_COLOR: bg_q <= cfg_value;
					default: ;
				endcase
			end
			valid_s1 <= active_q;
			if (cmd.exec && sweep_req) begin
				active_q <= 1'b1;
			end else if (active_q && dst_q == ADDR_W'(CELLS - 1)) begin
				active_q <= 1'b0;
			end
			if (cmd.exec) begin
				unique case (kind_q)
					tmcw_pkg::KIND_GLYPH: begin
						line_q <= line_nx;
						col_q  <= col_nx;
					end
					tmcw_pkg::KIND_MOVE: begin
						if (row_ok) begin
							line_q <= row_q[tmcw_pkg::LINE_W-1:0];
						end
						if (col_ok) begin
							col_q <= col_in_q[tmcw_pkg::COL_W-1:0];
						end
					end
					tmcw_pkg::KIND_CLEAR: begin
						line_q <= '0;
						col_q  <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, line_q} < 6'(SCREEN_ROWS))
		else $error("cursor row out of range");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < 8'(SCREEN_COLS))
		else $error("cursor column out of range");

	a_sweep_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && active_q) |-> src_q > SRC_W'(dst_s1))
		else $error("sweep read fell behind its write");

	a_stage_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(active_q))
		else $error("sweep write without a preceding read");

endmodule
`default_nettype wire

// ===== sv/text_mode_console_writer_core.sv =====
// Top level of the text-mode console writer.
//
//   Channel  Direction  Handshake                 Contents
//   s_*      in         s_tvalid / s_tready       one command item
//   m_*      out        m_tvalid / m_tready       cursor report and read data
//   cfg_*    in         cfg_valid / cfg_ready     color register write
//
// A glyph, newline, move or unknown kind goes from EXEC to RESP; a cell read also passes RDWAIT.
// A clear, a nonzero scroll and a glyph that runs past the last row walk the screen
// store one cell a cycle through its single write port; s_tready stays low meanwhile.
// The screen store has no reset; it is defined once a clear has run.
// A held result does not stop the next item from entering; the block waits
// only when a second result is ready before the first is taken.
`default_nettype none
module text_mode_console_writer_core #(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // glyph, target_row, target_col, scroll_count
	input  wire logic [2:0]  s_tuser,   // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // cursor_index, cursor_line, cursor_column, cell_data
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [3:0]  cfg_data
);

	tmcw_pkg::cmd_t    cmd;
	tmcw_pkg::status_t status;

	logic [tmcw_pkg::IDX_W-1:0]  out_index;
	logic [tmcw_pkg::LINE_W-1:0] out_line;
	logic [tmcw_pkg::COL_W-1:0]  out_column;
	logic [tmcw_pkg::CELL_W-1:0] out_cell;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {1'b0, out_cell, out_column, out_line, out_index};

	tmcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tmcw_dpath #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_we     (cfg_valid),
		.cfg_sel    (cfg_index),
		.cfg_value  (cfg_data),
		.in_kind    (s_tuser),
		.in_glyph   (s_tdata[7:0]),
		.in_row     (s_tdata[15:8]),
		.in_col     (s_tdata[23:16]),
		.in_count   (s_tdata[31:24]),
		.out_index  (out_index),
		.out_line   (out_line),
		.out_column (out_column),
		.out_cell   (out_cell)
	);

endmodule
`default_nettype wire
